@@ hw/rtl/sli_pkg.sv @@
// Shared constants and controller/datapath interface types for the list intersection block.
`timescale 1ns / 1ps

package sli_pkg;

  // Entries held per list
  localparam int LIST_CAPACITY = 32;
  // Matches emitted at most per walk
  localparam int MAX_RESULTS   = 32;

  localparam int ADDR_W  = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int CNT_W   = $clog2(LIST_CAPACITY + 1);
  localparam int DATA_W  = 32;
  localparam int MATCH_W = 6;

  typedef enum logic [1:0] {
    S_LOAD,
    S_PRIME,
    S_WALK
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // an input transfer is taken this cycle
    logic step;    // do one compare-and-advance of the walk
    logic finish;  // emit the last result and clear for the next job
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic close_both;  // the item being taken closes the second open list
    logic walk_more;   // both pointers are in range and the match limit is not hit
  } sts_t;

endpackage

@@ hw/rtl/sli_ctrl.sv @@
// Controller state machine: loading, read priming and the walk.
`timescale 1ns / 1ps

module sli_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sli_pkg::sts_t sts,
  output sli_pkg::cmd_t cmd,
  output logic          busy
);

  sli_pkg::state_t state;
  sli_pkg::state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sli_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      sli_pkg::S_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && sts.close_both) begin
          state_next = sli_pkg::S_PRIME;
        end
      end
      sli_pkg::S_PRIME: begin
        // first reads of both stores are in flight
        state_next = sli_pkg::S_WALK;
      end
      sli_pkg::S_WALK: begin
        if (sts.walk_more) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = sli_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = sli_pkg::S_LOAD;
      end
    endcase
  end

endmodule

@@ hw/rtl/sli_dp.sv @@
// Datapath: list stores, counts, walk pointers, pending match and result registers.
`timescale 1ns / 1ps

module sli_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  sli_pkg::cmd_t                      cmd,
  output sli_pkg::sts_t                      sts,
  input  logic                               list_select,
  input  logic signed [sli_pkg::DATA_W-1:0]  element,
  input  logic                               has_value,
  input  logic                               list_end,
  output logic                               result_strobe,
  output logic signed [sli_pkg::DATA_W-1:0]  match_value,
  output logic                               match_present,
  output logic                               final_match,
  output logic [sli_pkg::MATCH_W-1:0]        total_matches,
  output logic                               overflowed
);

  logic [sli_pkg::DATA_W-1:0] mem_a [sli_pkg::LIST_CAPACITY];
  logic [sli_pkg::DATA_W-1:0] mem_b [sli_pkg::LIST_CAPACITY];
  logic [sli_pkg::DATA_W-1:0] rd_a;
  logic [sli_pkg::DATA_W-1:0] rd_b;

  logic [sli_pkg::CNT_W-1:0]   cnt_a;
  logic [sli_pkg::CNT_W-1:0]   cnt_b;
  logic                        closed_a;
  logic                        closed_b;
  logic                        ovf;
  logic [sli_pkg::CNT_W-1:0]   ptr_a;
  logic [sli_pkg::CNT_W-1:0]   ptr_b;
  logic [sli_pkg::CNT_W-1:0]   ptr_a_next;
  logic [sli_pkg::CNT_W-1:0]   ptr_b_next;
  logic [sli_pkg::MATCH_W-1:0] n;
  logic [sli_pkg::DATA_W-1:0]  pend_value;
  logic                        pend_valid;

  logic                        sel_closed;
  logic                        take;
  logic [sli_pkg::CNT_W-1:0]   cnt_sel;
  logic                        room;
  logic                        wr_a;
  logic                        wr_b;
  logic                        ovf_set;
  logic                        closes;
  logic                        close_both;
  logic                        walk_more;
  logic                        less_ab;
  logic                        less_ba;
  logic                        equal;

  // Qualify the loading transfer
  always_comb begin
    sel_closed = list_select ? closed_b : closed_a;
    take       = cmd.load && !sel_closed;
    cnt_sel    = list_select ? cnt_b : cnt_a;
    room       = cnt_sel < sli_pkg::CNT_W'(sli_pkg::LIST_CAPACITY);
    wr_a       = take && has_value && room && !list_select;
    wr_b       = take && has_value && room && list_select;
    ovf_set    = take && has_value && !room;
    closes     = take && (list_end || !has_value);
    close_both = closes && (list_select ? closed_a : closed_b);
  end

  // Compare the heads of the two lists and pick the next pointers
  always_comb begin
    less_ab    = $signed(rd_a) < $signed(rd_b);
    less_ba    = $signed(rd_b) < $signed(rd_a);
    equal      = !less_ab && !less_ba;
    ptr_a_next = ptr_a;
    ptr_b_next = ptr_b;
    if (cmd.step) begin
      if (less_ab || equal) begin
        ptr_a_next = ptr_a + 1'b1;
      end
      if (less_ba || equal) begin
        ptr_b_next = ptr_b + 1'b1;
      end
    end
    walk_more = (ptr_a < cnt_a) && (ptr_b < cnt_b) &&
                (n < sli_pkg::MATCH_W'(sli_pkg::MAX_RESULTS));
  end

  // Report status to the controller
  assign sts = '{close_both: close_both, walk_more: walk_more};

  // Write the stores during loading and read at the next pointers
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a[sli_pkg::ADDR_W-1:0]] <= element;
    end
    if (wr_b) begin
      mem_b[cnt_b[sli_pkg::ADDR_W-1:0]] <= element;
    end
    rd_a <= mem_a[ptr_a_next[sli_pkg::ADDR_W-1:0]];
    rd_b <= mem_b[ptr_b_next[sli_pkg::ADDR_W-1:0]];
  end

  // Track counts, close flags, pointers and the pending match
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a      <= '0;
      cnt_b      <= '0;
      closed_a   <= 1'b0;
      closed_b   <= 1'b0;
      ovf        <= 1'b0;
      ptr_a      <= '0;
      ptr_b      <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.finish) begin
      cnt_a      <= '0;
      cnt_b      <= '0;
      closed_a   <= 1'b0;
      closed_b   <= 1'b0;
      ovf        <= 1'b0;
      ptr_a      <= '0;
      ptr_b      <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (wr_a) begin
        cnt_a <= cnt_a + 1'b1;
      end
      if (wr_b) begin
        cnt_b <= cnt_b + 1'b1;
      end
      if (ovf_set) begin
        ovf <= 1'b1;
      end
      if (closes && !list_select) begin
        closed_a <= 1'b1;
      end
      if (closes && list_select) begin
        closed_b <= 1'b1;
      end
      ptr_a <= ptr_a_next;
      ptr_b <= ptr_b_next;
      if (cmd.step && equal) begin
        n          <= n + 1'b1;
        pend_valid <= 1'b1;
      end
    end
  end

  // Hold the latest match until the walk shows whether it is the last one
  always_ff @(posedge clk) begin
    if (cmd.step && equal) begin
      pend_value <= rd_a;
    end
  end

  // Drive the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (cmd.step && equal && pend_valid) || cmd.finish;
    end
  end

  // Drive the result payload
  always_ff @(posedge clk) begin
    overflowed <= ovf;
    if (cmd.finish) begin
      match_value   <= pend_valid ? pend_value : '0;
      match_present <= pend_valid;
      final_match   <= 1'b1;
      total_matches <= n;
    end else begin
      match_value   <= pend_value;
      match_present <= 1'b1;
      final_match   <= 1'b0;
      total_matches <= '0;
    end
  end

  a_finish_gives_final : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_strobe && final_match)
    else $error("finish did not produce a final result");

  a_final_count : assert property (@(posedge clk) disable iff (rst)
    result_strobe && final_match && match_present |-> total_matches != '0)
    else $error("final match carries a zero count");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    cnt_a <= sli_pkg::CNT_W'(sli_pkg::LIST_CAPACITY) &&
    cnt_b <= sli_pkg::CNT_W'(sli_pkg::LIST_CAPACITY))
    else $error("list count beyond capacity");

  a_finish_clears : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> cnt_a == '0 && cnt_b == '0 && !closed_a && !closed_b && !ovf)
    else $error("job state not cleared after the walk");

  a_no_load_in_walk : assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !cmd.load && !wr_a && !wr_b)
    else $error("store written during the walk");

endmodule

@@ hw/rtl/sorted_list_intersection.sv @@
// Top level of the sorted list intersection block: controller plus datapath.
`timescale 1ns / 1ps

// Items are taken one per cycle while busy is low: list_select picks the
// list, has_value low or list_end high closes it, entries beyond 32 per list
// are dropped and flagged through overflowed, and items for a list already
// closed are ignored. The transfer that closes the second list raises busy;
// after a priming state the walk starts, doing one compare-and-advance per
// cycle on registered reads of the two list stores. Matches come out in
// ascending walk order, each strobed for one cycle on result_strobe, the
// last one marked by final_match and carrying total_matches; with no match a
// single result with match_present low appears. The receiver must take
// every strobed result, which can arrive on consecutive cycles. busy is low
// again in the cycle that carries the final result, with all counts cleared.

module sorted_list_intersection (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               list_select,
  input  logic signed [sli_pkg::DATA_W-1:0]  element,
  input  logic                               has_value,
  input  logic                               list_end,
  output logic                               result_strobe,
  output logic signed [sli_pkg::DATA_W-1:0]  match_value,
  output logic                               match_present,
  output logic                               final_match,
  output logic [sli_pkg::MATCH_W-1:0]        total_matches,
  output logic                               overflowed
);

  sli_pkg::cmd_t cmd;
  sli_pkg::sts_t sts;

  sli_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  sli_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .list_select   (list_select),
    .element       (element),
    .has_value     (has_value),
    .list_end      (list_end),
    .result_strobe (result_strobe),
    .match_value   (match_value),
    .match_present (match_present),
    .final_match   (final_match),
    .total_matches (total_matches),
    .overflowed    (overflowed)
  );

endmodule
